### rtl/fmts_pkg.sv
// ----------------------------------------------------------------------------
// fmts_pkg
// Shared types, constants and helpers for the fan mode/timer/swing controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fmts_pkg;

  localparam int unsigned ButtonCount = 5;
  localparam int unsigned CodeW       = 3;

  // button codes, lowest pressed button wins
  localparam logic [CodeW-1:0] BTN_MODE  = 3'd0;
  localparam logic [CodeW-1:0] BTN_TIMER = 3'd1;
  localparam logic [CodeW-1:0] BTN_ADD   = 3'd2;
  localparam logic [CodeW-1:0] BTN_SUB   = 3'd3;
  localparam logic [CodeW-1:0] BTN_SWING = 3'd4;
  localparam logic [CodeW-1:0] BTN_NONE  = CodeW'(ButtonCount);

  localparam logic [11:0] TimeMax  = 12'd3600;
  localparam logic [11:0] TimeStep = 12'd60;

  localparam logic [1:0] FAN_OFF  = 2'd0;
  localparam logic [1:0] FAN_SLOW = 2'd1;
  localparam logic [1:0] FAN_MID  = 2'd2;
  localparam logic [1:0] FAN_FAST = 2'd3;

  // pulse = 1000 + angle*4000/180 = 1000 + floor(angle*200/9)
  // floor(x/9) = (x*58255) >> 19, exact for x below 74898; 200*58255 folded in
  localparam logic [12:0] PulseMin   = 13'd1000;
  localparam logic [31:0] PulseScale = 32'd11651000;
  localparam int unsigned PulseShift = 19;

  typedef enum logic [2:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_INTERVAL = 3'd1,
    CFG_MIN_DEG  = 3'd2,
    CFG_MAX_DEG  = 3'd3,
    CFG_CTR_DEG  = 3'd4,
    CFG_DUTY_LO  = 3'd5,
    CFG_DUTY_MED = 3'd6,
    CFG_DUTY_HI  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0] debounce;
    logic [7:0] interval;
    logic [7:0] min_deg;
    logic [7:0] max_deg;
    logic [7:0] ctr_deg;
    logic [9:0] duty_lo;
    logic [9:0] duty_med;
    logic [9:0] duty_hi;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [11:0]      secs;
    logic             run;
    logic             swing;
    logic [7:0]       angle;
    logic             up;
    logic [7:0]       ticks;
    logic [CodeW-1:0] prev_btn;
    logic [CodeW-1:0] acc_btn;
    logic [2:0]       stable_cnt;
  } state_t;

  function automatic logic [12:0] angle_to_pulse(logic [7:0] angle);
    logic [31:0] prod;
    prod = {24'd0, angle} * PulseScale;
    return PulseMin + 13'(prod >> PulseShift);
  endfunction

endpackage

`default_nettype wire

### rtl/fmts_if.sv
// ----------------------------------------------------------------------------
// fmts_if
// Valid/ready channels for control ticks in and controller status out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmts_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] button_pins;
  logic       second_elapsed;

  modport source (output valid, button_pins, second_elapsed, input ready);
  modport sink   (input valid, button_pins, second_elapsed, output ready);
endinterface

interface fmts_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  motor_duty;
  logic [12:0] servo_pulse;
  logic [1:0]  fan_mode;
  logic [11:0] remaining_seconds;
  logic        countdown_active;
  logic        swing_active;
  logic [7:0]  swing_angle;

  modport source (output valid, motor_duty, servo_pulse, fan_mode, remaining_seconds,
                  countdown_active, swing_active, swing_angle, input ready);
  modport sink   (input valid, motor_duty, servo_pulse, fan_mode, remaining_seconds,
                  countdown_active, swing_active, swing_angle, output ready);
endinterface

`default_nettype wire

### rtl/fmts_tick.sv
// ----------------------------------------------------------------------------
// fmts_tick
// Next-state logic for one control tick: debounce, button action, countdown,
// swing step and motor duty selection.
// ----------------------------------------------------------------------------
`default_nettype none

module fmts_tick (
  input  wire fmts_pkg::cfg_t   cfg_i,
  input  wire fmts_pkg::state_t state_i,
  input  wire logic [4:0]       button_pins_i,
  input  wire logic             second_elapsed_i,
  output fmts_pkg::state_t      state_o,
  output logic [9:0]            duty_o
);

  logic [fmts_pkg::CodeW-1:0] code;
  logic                       accept;
  logic [12:0]                add_sum;
  logic [7:0]                 ticks_inc;
  fmts_pkg::state_t           nxt;

  // priority encoder, lowest active-low pin wins
  always_comb begin
    code = fmts_pkg::BTN_NONE;
    for (int i = fmts_pkg::ButtonCount - 1; i >= 0; i--) begin
      if (!button_pins_i[i]) begin
        code = fmts_pkg::CodeW'(i);
      end
    end
  end

  assign add_sum   = {1'b0, state_i.secs} + {1'b0, fmts_pkg::TimeStep};
  assign ticks_inc = state_i.ticks + 8'd1;

  always_comb begin
    nxt = state_i;

    // debounce
    if (code == state_i.prev_btn) begin
      if (state_i.stable_cnt < cfg_i.debounce) begin
        nxt.stable_cnt = state_i.stable_cnt + 3'd1;
      end
    end else begin
      nxt.stable_cnt = '0;
    end
    accept = (nxt.stable_cnt >= cfg_i.debounce) && (code != state_i.acc_btn);
    if (accept) begin
      nxt.acc_btn = code;
      case (code)
        fmts_pkg::BTN_MODE:  nxt.mode = state_i.mode + 2'd1;
        fmts_pkg::BTN_TIMER: nxt.run = ~state_i.run;
        fmts_pkg::BTN_ADD: begin
          if (add_sum > {1'b0, fmts_pkg::TimeMax}) begin
            nxt.secs = fmts_pkg::TimeStep;
          end else begin
            nxt.secs = add_sum[11:0];
          end
        end
        fmts_pkg::BTN_SUB: begin
          if (state_i.secs == '0) begin
            nxt.secs = fmts_pkg::TimeMax;
          end else if (state_i.secs >= fmts_pkg::TimeStep) begin
            nxt.secs = state_i.secs - fmts_pkg::TimeStep;
          end
        end
        fmts_pkg::BTN_SWING: nxt.swing = ~state_i.swing;
        default: ;
      endcase
    end
    nxt.prev_btn = code;

    // countdown; expiry stops everything and recenters the servo
    if (second_elapsed_i && nxt.run && (nxt.secs != '0)) begin
      nxt.secs = nxt.secs - 12'd1;
      if (nxt.secs == '0) begin
        nxt.run   = 1'b0;
        nxt.mode  = fmts_pkg::FAN_OFF;
        nxt.swing = 1'b0;
        nxt.angle = cfg_i.ctr_deg;
        nxt.up    = 1'b1;
      end
    end

    // swing step; tick counter runs regardless of swing enable
    if (ticks_inc >= cfg_i.interval) begin
      nxt.ticks = '0;
      if (nxt.swing) begin
        nxt.angle = nxt.up ? nxt.angle + 8'd1 : nxt.angle - 8'd1;
        if (nxt.angle >= cfg_i.max_deg) begin
          nxt.angle = cfg_i.max_deg;
          nxt.up    = 1'b0;
        end
        if (nxt.angle <= cfg_i.min_deg) begin
          nxt.angle = cfg_i.min_deg;
          nxt.up    = 1'b1;
        end
      end
    end else begin
      nxt.ticks = ticks_inc;
    end
  end

  assign state_o = nxt;

  always_comb begin
    case (nxt.mode)
      fmts_pkg::FAN_SLOW: duty_o = cfg_i.duty_lo;
      fmts_pkg::FAN_MID:  duty_o = cfg_i.duty_med;
      fmts_pkg::FAN_FAST: duty_o = cfg_i.duty_hi;
      default:            duty_o = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/fan_mode_timer_swing_controller.sv
// ----------------------------------------------------------------------------
// fan_mode_timer_swing_controller
// Fan power mode, countdown timer and servo swing, one control tick per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one transfer per control tick (active-low button pins, second flag).
//   out_o : one status transfer per tick: motor duty, servo pulse, mode, timer,
//           run and swing flags, servo angle, all after that tick's updates.
//   cfg_* : register writes, index 0..7 (debounce, sweep interval, swing min,
//           max, center, duty low/med/high); write only while idle.
//   Path: a tick is registered on input, then goes through the tick logic, and
//   its status is registered in the result register. Throughput: one tick per
//   cycle unless out_o stalls; the tick state register is the only loop.
//   Stall: while out_o is held, the pending status stays and one more tick is
//   held in the input register; in_i.ready drops only when both are full.
//   Reset: registers return to defaults, mode stop, timer 0, angle 90, no
//   button held; nothing is pending on either channel.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_mode_timer_swing_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [9:0]  cfg_data_i,
  fmts_in_if.sink          in_i,
  fmts_out_if.source       out_o
);

  fmts_pkg::cfg_t   cfg_q;
  fmts_pkg::state_t state_q, state_d;

  logic        in_valid_q;
  logic [4:0]  pins_q;
  logic        sec_q;
  logic        out_valid_q;
  logic        advance, fire;
  logic [9:0]  duty_d, duty_q;
  logic [1:0]  mode_q;
  logic [11:0] secs_q;
  logic        run_q, swing_q;
  logic [7:0]  angle_q;

  assign advance    = !out_valid_q || out_o.ready;
  assign fire       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce <= 3'd5;
      cfg_q.interval <= 8'd150;
      cfg_q.min_deg  <= 8'd45;
      cfg_q.max_deg  <= 8'd135;
      cfg_q.ctr_deg  <= 8'd90;
      cfg_q.duty_lo  <= 10'd300;
      cfg_q.duty_med <= 10'd600;
      cfg_q.duty_hi  <= 10'd950;
    end else if (cfg_we_i) begin
      case (fmts_pkg::cfg_idx_e'(cfg_idx_i))
        fmts_pkg::CFG_DEBOUNCE: cfg_q.debounce <= cfg_data_i[2:0];
        fmts_pkg::CFG_INTERVAL: cfg_q.interval <= cfg_data_i[7:0];
        fmts_pkg::CFG_MIN_DEG:  cfg_q.min_deg  <= cfg_data_i[7:0];
        fmts_pkg::CFG_MAX_DEG:  cfg_q.max_deg  <= cfg_data_i[7:0];
        fmts_pkg::CFG_CTR_DEG:  cfg_q.ctr_deg  <= cfg_data_i[7:0];
        fmts_pkg::CFG_DUTY_LO:  cfg_q.duty_lo  <= cfg_data_i;
        fmts_pkg::CFG_DUTY_MED: cfg_q.duty_med <= cfg_data_i;
        fmts_pkg::CFG_DUTY_HI:  cfg_q.duty_hi  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      pins_q <= in_i.button_pins;
      sec_q  <= in_i.second_elapsed;
    end
  end

  fmts_tick u_tick (
    .cfg_i            (cfg_q),
    .state_i          (state_q),
    .button_pins_i    (pins_q),
    .second_elapsed_i (sec_q),
    .state_o          (state_d),
    .duty_o           (duty_d)
  );

  // tick state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode       <= fmts_pkg::FAN_OFF;
      state_q.secs       <= '0;
      state_q.run        <= 1'b0;
      state_q.swing      <= 1'b0;
      state_q.angle      <= 8'd90;
      state_q.up         <= 1'b1;
      state_q.ticks      <= '0;
      state_q.prev_btn   <= fmts_pkg::BTN_NONE;
      state_q.acc_btn    <= fmts_pkg::BTN_NONE;
      state_q.stable_cnt <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      duty_q  <= duty_d;
      mode_q  <= state_d.mode;
      secs_q  <= state_d.secs;
      run_q   <= state_d.run;
      swing_q <= state_d.swing;
      angle_q <= state_d.angle;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.motor_duty        = duty_q;
  assign out_o.servo_pulse       = fmts_pkg::angle_to_pulse(angle_q);
  assign out_o.fan_mode          = mode_q;
  assign out_o.remaining_seconds = secs_q;
  assign out_o.countdown_active  = run_q;
  assign out_o.swing_active      = swing_q;
  assign out_o.swing_angle       = angle_q;

endmodule

`default_nettype wire

### bench/tb_fan_mode_timer_swing_controller.sv
// ----------------------------------------------------------------------------
// tb_fan_mode_timer_swing_controller
// Drives control ticks into the fan controller and checks every status
// transfer against a tick-accurate model of the controller (button debounce,
// mode/timer/swing actions, countdown expiry, swing sweep, duty and pulse).
// Covers directed edge cases, a countdown-to-expiry scenario and random
// press/release sequences over several register settings, with random
// source gaps and sink stalls.
// ----------------------------------------------------------------------------

module tb_fan_mode_timer_swing_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseTicks = 125;
  localparam int unsigned PhaseCount = 10;

  typedef struct packed {
    logic [4:0] pins;
    logic       sec;
  } tick_t;

  typedef struct packed {
    logic [9:0]  duty;
    logic [12:0] pulse;
    logic [1:0]  mode;
    logic [11:0] secs;
    logic        run;
    logic        swing;
    logic [7:0]  angle;
  } fan_status_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [9:0] cfg_data_i;

  fmts_in_if  tick_if ();
  fmts_out_if status_if ();

  fan_mode_timer_swing_controller i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (tick_if),
    .out_o      (status_if)
  );

  // model copy of registers and tick state
  fmts_pkg::cfg_t   fan_cfg;
  fmts_pkg::state_t fan_st;

  tick_t       tick_q[$];
  fan_status_t status_q[$];
  tick_t       tick_next;
  fan_status_t status_want;

  int unsigned ticks_issued;
  int unsigned ticks_taken;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_gap;
  int unsigned stall_gap;
  int unsigned idle_odds;
  int unsigned sec_pct;
  bit          idle_on;
  bit          tick_xfer;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // controller model: one call per accepted tick
  // ---------------------------------------------------------------------------
  function automatic fan_status_t advance_tick(logic [4:0] pins, logic sec);
    fan_status_t                res;
    logic [fmts_pkg::CodeW-1:0] code;
    int unsigned                pulse;

    code = fmts_pkg::BTN_NONE;
    for (int i = fmts_pkg::ButtonCount - 1; i >= 0; i--) begin
      if (!pins[i]) code = fmts_pkg::CodeW'(i);
    end

    if (code == fan_st.prev_btn) begin
      if (fan_st.stable_cnt < fan_cfg.debounce) fan_st.stable_cnt++;
    end else begin
      fan_st.stable_cnt = '0;
    end
    if (fan_st.stable_cnt >= fan_cfg.debounce && code != fan_st.acc_btn) begin
      fan_st.acc_btn = code;
      case (code)
        fmts_pkg::BTN_MODE:  fan_st.mode = fan_st.mode + 2'd1;
        fmts_pkg::BTN_TIMER: fan_st.run = ~fan_st.run;
        fmts_pkg::BTN_ADD: begin
          fan_st.secs = fan_st.secs + fmts_pkg::TimeStep;
          if (fan_st.secs > fmts_pkg::TimeMax) fan_st.secs = fmts_pkg::TimeStep;
        end
        fmts_pkg::BTN_SUB: begin
          if (fan_st.secs == '0) fan_st.secs = fmts_pkg::TimeMax;
          else if (fan_st.secs >= fmts_pkg::TimeStep)
            fan_st.secs = fan_st.secs - fmts_pkg::TimeStep;
        end
        fmts_pkg::BTN_SWING: fan_st.swing = ~fan_st.swing;
        default: ;
      endcase
    end
    fan_st.prev_btn = code;

    if (sec && fan_st.run && fan_st.secs != '0) begin
      fan_st.secs--;
      if (fan_st.secs == '0) begin
        fan_st.run   = 1'b0;
        fan_st.mode  = fmts_pkg::FAN_OFF;
        fan_st.swing = 1'b0;
        fan_st.angle = fan_cfg.ctr_deg;
        fan_st.up    = 1'b1;
      end
    end

    // tick counter runs even with swing off
    fan_st.ticks = fan_st.ticks + 8'd1;
    if (fan_st.ticks >= fan_cfg.interval) begin
      fan_st.ticks = '0;
      if (fan_st.swing) begin
        fan_st.angle = fan_st.up ? fan_st.angle + 8'd1 : fan_st.angle - 8'd1;
        if (fan_st.angle >= fan_cfg.max_deg) begin
          fan_st.angle = fan_cfg.max_deg;
          fan_st.up    = 1'b0;
        end
        if (fan_st.angle <= fan_cfg.min_deg) begin
          fan_st.angle = fan_cfg.min_deg;
          fan_st.up    = 1'b1;
        end
      end
    end

    case (fan_st.mode)
      fmts_pkg::FAN_SLOW: res.duty = fan_cfg.duty_lo;
      fmts_pkg::FAN_MID:  res.duty = fan_cfg.duty_med;
      fmts_pkg::FAN_FAST: res.duty = fan_cfg.duty_hi;
      default:            res.duty = '0;
    endcase
    pulse     = 1000 + (int'(fan_st.angle) * 4000) / 180;
    res.pulse = pulse[12:0];
    res.mode  = fan_st.mode;
    res.secs  = fan_st.secs;
    res.run   = fan_st.run;
    res.swing = fan_st.swing;
    res.angle = fan_st.angle;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: ticks and sink ready change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      tick_if.valid   <= 1'b0;
      status_if.ready <= 1'b0;
    end else begin
      if (!tick_if.valid || tick_xfer) begin
        if (send_gap != 0) begin
          send_gap--;
          tick_if.valid <= 1'b0;
        end else if (idle_on && $urandom_range(1, idle_odds) == 1) begin
          send_gap = $urandom_range(0, 11);
          tick_if.valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          tick_next = tick_q.pop_front();
          tick_if.valid          <= 1'b1;
          tick_if.button_pins    <= tick_next.pins;
          tick_if.second_elapsed <= tick_next.sec;
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
      if (stall_gap != 0) begin
        stall_gap--;
        status_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(1, idle_odds) == 1) begin
        stall_gap = $urandom_range(0, 11);
        status_if.ready <= 1'b0;
      end else begin
        status_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each tick transfer, check each status transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tick_xfer <= tick_if.valid && tick_if.ready;
    if (tick_if.valid && tick_if.ready) begin
      status_q.push_back(advance_tick(tick_if.button_pins, tick_if.second_elapsed));
      ticks_taken++;
    end
    if (status_if.valid && status_if.ready) begin
      if (status_q.size() == 0) begin
        $display("%0t: status transfer with none expected, actual duty %0d angle %0d",
                 $time, status_if.motor_duty, status_if.swing_angle);
        mismatches++;
      end else begin
        status_want = status_q.pop_front();
        check_field("motor_duty", 32'(status_want.duty), 32'(status_if.motor_duty));
        check_field("servo_pulse", 32'(status_want.pulse), 32'(status_if.servo_pulse));
        check_field("fan_mode", 32'(status_want.mode), 32'(status_if.fan_mode));
        check_field("remaining_seconds", 32'(status_want.secs),
                    32'(status_if.remaining_seconds));
        check_field("countdown_active", 32'(status_want.run),
                    32'(status_if.countdown_active));
        check_field("swing_active", 32'(status_want.swing), 32'(status_if.swing_active));
        check_field("swing_angle", 32'(status_want.angle), 32'(status_if.swing_angle));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_tick(input logic [4:0] pins, input logic sec);
    tick_q.push_back(tick_t'{pins: pins, sec: sec});
    ticks_issued++;
  endtask

  function automatic logic rand_sec();
    return $urandom_range(0, 99) < sec_pct;
  endfunction

  // pins that encode to the given button; bits above it are don't-care
  function automatic logic [4:0] pins_for(logic [fmts_pkg::CodeW-1:0] code);
    logic [4:0] p;
    p = 5'($urandom);
    if (code == fmts_pkg::BTN_NONE) return 5'h1F;
    for (int i = 0; i < fmts_pkg::ButtonCount; i++) begin
      if (i < code) p[i] = 1'b1;
    end
    p[code] = 1'b0;
    return p;
  endfunction

  task automatic hold_code(input logic [fmts_pkg::CodeW-1:0] code, input int n);
    repeat (n) push_tick(pins_for(code), rand_sec());
  endtask

  task automatic wait_idle();
    while (ticks_taken != ticks_issued || status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // unused upper data bits carry junk, the register keeps only its width
  task automatic write_reg(input fmts_pkg::cfg_idx_e idx, input logic [9:0] val,
                           input logic [9:0] mask);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= (val & mask) | (10'($urandom) & ~mask);
  endtask

  task automatic program_regs(input fmts_pkg::cfg_t c);
    write_reg(fmts_pkg::CFG_DEBOUNCE, 10'(c.debounce), 10'h007);
    write_reg(fmts_pkg::CFG_INTERVAL, 10'(c.interval), 10'h0FF);
    write_reg(fmts_pkg::CFG_MIN_DEG, 10'(c.min_deg), 10'h0FF);
    write_reg(fmts_pkg::CFG_MAX_DEG, 10'(c.max_deg), 10'h0FF);
    write_reg(fmts_pkg::CFG_CTR_DEG, 10'(c.ctr_deg), 10'h0FF);
    write_reg(fmts_pkg::CFG_DUTY_LO, c.duty_lo, 10'h3FF);
    write_reg(fmts_pkg::CFG_DUTY_MED, c.duty_med, 10'h3FF);
    write_reg(fmts_pkg::CFG_DUTY_HI, c.duty_hi, 10'h3FF);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    fan_cfg = c;
    @(posedge clk_i);
  endtask

  function automatic fmts_pkg::cfg_t rand_cfg(int k);
    fmts_pkg::cfg_t c;
    c.debounce = 3'($urandom_range(0, 3));
    c.interval = 8'($urandom_range(0, 6));
    c.min_deg  = 8'($urandom_range(0, 170));
    c.max_deg  = c.min_deg + 8'($urandom_range(1, 10));
    c.ctr_deg  = 8'($urandom_range(0, 180));
    c.duty_lo  = 10'($urandom_range(0, 1023));
    c.duty_med = 10'($urandom_range(0, 1023));
    c.duty_hi  = 10'($urandom_range(0, 1023));
    case (k)
      0: begin
        c.debounce = 3'd7;
        c.interval = 8'd255;
        c.min_deg  = 8'd0;
        c.max_deg  = 8'd180;
        c.ctr_deg  = 8'd180;
        c.duty_lo  = 10'd0;
        c.duty_med = 10'd1000;
        c.duty_hi  = 10'd1023;
      end
      1: begin
        // inverted limits
        c.debounce = 3'd1;
        c.interval = 8'd1;
        c.min_deg  = 8'd180;
        c.max_deg  = 8'd0;
        c.ctr_deg  = 8'd0;
      end
      2: begin
        // limits above 180, upward step wraps past 255
        c.debounce = 3'd0;
        c.interval = 8'd0;
        c.min_deg  = 8'd250;
        c.max_deg  = 8'd255;
        c.ctr_deg  = 8'd255;
      end
      3: begin
        c.debounce = 3'd6;
        c.min_deg  = 8'd0;
        c.max_deg  = 8'd3;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic run_random_phase(input int k, input bit quiet);
    int unsigned start;
    int          b;
    wait_idle();
    program_regs(rand_cfg(k));
    sec_pct   = $urandom_range(30, 90);
    idle_odds = $urandom_range(2, 16);
    idle_on   = !quiet;
    start     = ticks_issued;
    while (ticks_issued - start < PhaseTicks) begin
      if ($urandom_range(0, 99) < 80) begin
        // clean press then clean release, long enough to pass debounce
        b = $urandom_range(0, fmts_pkg::ButtonCount - 1);
        hold_code(fmts_pkg::CodeW'(b), int'(fan_cfg.debounce) + 1 + $urandom_range(0, 2));
        hold_code(fmts_pkg::BTN_NONE, int'(fan_cfg.debounce) + 1 + $urandom_range(0, 2));
      end else begin
        repeat ($urandom_range(1, 4)) push_tick(5'($urandom), rand_sec());
      end
    end
  endtask

  initial begin
    fmts_pkg::cfg_t c;

    tick_if.valid          = 1'b0;
    tick_if.button_pins    = 5'h1F;
    tick_if.second_elapsed = 1'b0;
    status_if.ready        = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = fmts_pkg::CFG_DEBOUNCE;
    cfg_data_i = '0;
    idle_on    = 1'b1;
    idle_odds  = 8;
    sec_pct    = 50;
    rst_ni     = 1'b0;
    fan_cfg = '{debounce: 3'd5, interval: 8'd150, min_deg: 8'd45, max_deg: 8'd135,
                ctr_deg: 8'd90, duty_lo: 10'd300, duty_med: 10'd600, duty_hi: 10'd950};
    fan_st  = '{mode: fmts_pkg::FAN_OFF, secs: 12'd0, run: 1'b0, swing: 1'b0,
                angle: 8'd90, up: 1'b1, ticks: 8'd0, prev_btn: fmts_pkg::BTN_NONE,
                acc_btn: fmts_pkg::BTN_NONE, stable_cnt: 3'd0};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: immediate acceptance, swing step every tick, other regs at reset
    c = fan_cfg;
    c.debounce = 3'd0;
    c.interval = 8'd0;
    program_regs(c);
    push_tick(5'h1F, 1'b0);
    push_tick(5'h1E, 1'b0);   // mode -> low
    push_tick(5'h1F, 1'b0);
    push_tick(5'h00, 1'b1);   // all pressed, lowest wins -> medium
    push_tick(5'h1F, 1'b0);
    push_tick(5'h1D, 1'b1);   // run with zero time: nothing counts
    push_tick(5'h1F, 1'b1);
    push_tick(5'h1B, 1'b0);   // +60
    push_tick(5'h1F, 1'b0);
    push_tick(5'h17, 1'b0);   // -60 -> 0
    push_tick(5'h1F, 1'b0);
    push_tick(5'h17, 1'b0);   // 0 -> 3600
    push_tick(5'h1F, 1'b0);
    push_tick(5'h1B, 1'b0);   // above 3600 wraps to 60
    push_tick(5'h1F, 1'b0);
    push_tick(5'h0F, 1'b0);   // swing on
    push_tick(5'h10, 1'b0);   // mode -> high
    push_tick(5'h1F, 1'b1);   // one second off the timer
    push_tick(5'h1E, 1'b0);   // mode wraps to stop
    push_tick(5'h1F, 1'b0);
    push_tick(5'h1D, 1'b0);   // run off
    push_tick(5'h1F, 1'b1);

    // countdown: -60 on a value over a minute, then expiry with mode on and swing off
    wait_idle();
    c.debounce = 3'd0;
    c.interval = 8'd2;
    c.min_deg  = 8'd80;
    c.max_deg  = 8'd100;
    c.ctr_deg  = 8'd70;
    program_regs(c);
    push_tick(5'h1B, 1'b0);
    push_tick(5'h1F, 1'b0);
    push_tick(5'h0F, 1'b0);
    push_tick(5'h1F, 1'b0);
    push_tick(5'h1E, 1'b0);
    push_tick(5'h1F, 1'b0);
    push_tick(5'h1D, 1'b0);
    push_tick(5'h1F, 1'b0);
    repeat (30) push_tick(5'h1F, 1'b1);
    push_tick(5'h17, 1'b0);
    push_tick(5'h1F, 1'b0);
    repeat (35) push_tick(5'h1F, 1'b1);

    for (int k = 0; k < PhaseCount; k++) run_random_phase(k, k == PhaseCount - 1);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
